>>> rtl/sle_pkg.sv
// Shared types, constants and the scancode table of the scancode line editor.
// Depends on nothing; every other file in rtl but sle_ram imports it.
`default_nettype none

package sle_pkg;

	localparam int unsigned LINE_CAPACITY_DEF = 64;
	localparam int unsigned MAX_RESULTS       = 64;
	localparam int unsigned IDX_W             = $clog2(MAX_RESULTS);
	localparam int unsigned QUEUE_DEPTH       = 2;

	localparam logic [1:0] KIND_ECHO   = 2'd0;
	localparam logic [1:0] KIND_LINE   = 2'd1;
	localparam logic [1:0] KIND_NOLINE = 2'd2;

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_BS  = 8'h08;
	localparam logic [7:0] CH_NL  = 8'h0A;
	localparam logic [7:0] CH_SP  = 8'h20;

	typedef enum logic [1:0] {
		OP_PRINT,
		OP_BKSP,
		OP_ENTER,
		OP_READ
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] ch;
		logic [6:0] limit;
	} cmd_t;

	// Set-1 make code to ASCII; zero marks a key with no character.
	function automatic logic [7:0] key_map(input logic [6:0] code);
		logic [7:0] c;
		c = CH_NUL;
		case (code)
			7'h02: c = 8'h31;
			7'h03: c = 8'h32;
			7'h04: c = 8'h33;
			7'h05: c = 8'h34;
			7'h06: c = 8'h35;
			7'h07: c = 8'h36;
			7'h08: c = 8'h37;
			7'h09: c = 8'h38;
			7'h0A: c = 8'h39;
			7'h0B: c = 8'h30;
			7'h0C: c = 8'h2D;
			7'h0D: c = 8'h3D;
			7'h0E: c = CH_BS;
			7'h0F: c = 8'h09;
			7'h10: c = 8'h71;
			7'h11: c = 8'h77;
			7'h12: c = 8'h65;
			7'h13: c = 8'h72;
			7'h14: c = 8'h74;
			7'h15: c = 8'h79;
			7'h16: c = 8'h75;
			7'h17: c = 8'h69;
			7'h18: c = 8'h6F;
			7'h19: c = 8'h70;
			7'h1A: c = 8'h5B;
			7'h1B: c = 8'h5D;
			7'h1C: c = CH_NL;
			7'h1E: c = 8'h61;
			7'h1F: c = 8'h73;
			7'h20: c = 8'h64;
			7'h21: c = 8'h66;
			7'h22: c = 8'h67;
			7'h23: c = 8'h68;
			7'h24: c = 8'h6A;
			7'h25: c = 8'h6B;
			7'h26: c = 8'h6C;
			7'h27: c = 8'h3B;
			7'h28: c = 8'h27;
			7'h29: c = 8'h60;
			7'h2B: c = 8'h5C;
			7'h2C: c = 8'h7A;
			7'h2D: c = 8'h78;
			7'h2E: c = 8'h63;
			7'h2F: c = 8'h76;
			7'h30: c = 8'h62;
			7'h31: c = 8'h6E;
			7'h32: c = 8'h6D;
			7'h33: c = 8'h2C;
			7'h34: c = 8'h2E;
			7'h35: c = 8'h2F;
			7'h37: c = 8'h2A;
			7'h39: c = CH_SP;
			7'h4A: c = 8'h2D;
			7'h4E: c = 8'h2B;
			default: c = CH_NUL;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

>>> rtl/sle_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
`default_nettype none

module sle_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

>>> rtl/sle_front.sv
// Front end: takes input beats, maps scancodes to characters and turns each
// beat into an editing command, or drops it. Depends on sle_pkg.
`default_nettype none

module sle_front import sle_pkg::*; (
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,
	input  wire logic [0:0]  s_axis_tuser,
	output logic             cmd_valid,
	input  wire logic        cmd_ready,
	output cmd_t             cmd
);

	logic [7:0] code;
	logic [7:0] ch;
	logic       keep;

	assign code = s_axis_tdata[7:0];
	assign ch   = key_map(code[6:0]);

	always_comb begin
		cmd.ch    = ch;
		cmd.limit = s_axis_tdata[14:8];
		cmd.op    = OP_PRINT;
		keep      = 1'b1;
		if (s_axis_tuser[0]) begin
			cmd.op = OP_READ;
		end else if (code[7] || ch == CH_NUL) begin
			// Break codes and keys without a character leave no trace.
			keep = 1'b0;
		end else if (ch == CH_NL) begin
			cmd.op = OP_ENTER;
		end else if (ch == CH_BS) begin
			cmd.op = OP_BKSP;
		end
	end

	assign s_axis_tready = cmd_ready;
	assign cmd_valid     = s_axis_tvalid && keep;

endmodule

`default_nettype wire

>>> rtl/sle_queue.sv
// Short command queue between the front end and the line engine.
// Depends on sle_pkg.
`default_nettype none

module sle_queue import sle_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  cmd_t      in_cmd,
	output logic      out_valid,
	input  wire logic out_pop,
	output cmd_t      out_cmd
);

	localparam int unsigned QAW = $clog2(QUEUE_DEPTH);

	cmd_t           mem_q [QUEUE_DEPTH];
	logic [QAW-1:0] wr_q;
	logic [QAW-1:0] rd_q;
	logic [QAW:0]   cnt_q;
	logic           push;

	assign in_ready  = cnt_q != (QAW+1)'(QUEUE_DEPTH);
	assign out_valid = cnt_q != '0;
	assign out_cmd   = mem_q[rd_q];
	assign push      = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (out_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !out_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && out_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= in_cmd;
		end
	end

endmodule

`default_nettype wire

>>> rtl/sle_back.sv
// Line engine: holds the edit position, the ready flag and the line store,
// carries out queued commands and drives the output register.
// Depends on sle_pkg and sle_ram.
`default_nettype none

module sle_back import sle_pkg::*; #(
	parameter int unsigned LINE_CAPACITY = LINE_CAPACITY_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cmd_valid,
	output logic             cmd_pop,
	input  cmd_t             cmd,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [15:0]      m_axis_tdata,
	output logic [1:0]       m_axis_tuser,
	output logic             m_axis_tlast
);

	localparam int unsigned PW      = $clog2(LINE_CAPACITY);
	localparam int unsigned LEN_MAX =
		(LINE_CAPACITY < MAX_RESULTS - 1) ? LINE_CAPACITY : MAX_RESULTS - 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_BS_SPACE,
		ST_BS_LAST,
		ST_STREAM
	} state_t;

	state_t           state_q;
	logic [PW-1:0]    pos_q;
	logic             ready_q;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] bound_q;
	logic             m_valid_q;
	logic [1:0]       kind_q;
	logic [7:0]       char_q;
	logic             rdy_out_q;
	logic             last_q;

	logic             load;
	logic             pos_ok;
	logic             term;
	logic [6:0]       max_chars;
	logic [IDX_W-1:0] bound_d;
	logic [IDX_W-1:0] rd_idx;
	logic             we;
	logic [7:0]       wdata;
	logic [7:0]       rdata;

	// The output register may be loaded when it is empty or its beat leaves now.
	assign load    = !m_valid_q || m_axis_tready;
	assign cmd_pop = (state_q == ST_IDLE) && cmd_valid && load;
	assign pos_ok  = pos_q != PW'(LINE_CAPACITY - 1);
	assign term    = (idx_q == bound_q) || (rdata == CH_NUL);

	assign max_chars = (cmd.limit == 7'd0) ? 7'd0 : cmd.limit - 7'd1;
	assign bound_d   = (max_chars > 7'(LEN_MAX)) ? IDX_W'(LEN_MAX) : IDX_W'(max_chars);

	assign we    = cmd_pop && ((cmd.op == OP_PRINT && pos_ok) || cmd.op == OP_ENTER);
	assign wdata = (cmd.op == OP_ENTER) ? CH_NUL : cmd.ch;

	// The store is read every cycle; the address runs one ahead while streaming
	// so that the character for the next beat is ready when that beat is built.
	always_comb begin
		rd_idx = '0;
		if (state_q == ST_STREAM) begin
			rd_idx = idx_q;
			if (load && !term) begin
				rd_idx = idx_q + 1'b1;
			end
		end
	end

	sle_ram #(
		.WIDTH(8),
		.DEPTH(LINE_CAPACITY)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(pos_q),
		.wdata(wdata),
		.raddr(PW'(rd_idx)),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			pos_q     <= '0;
			ready_q   <= 1'b0;
			idx_q     <= '0;
			bound_q   <= '0;
			m_valid_q <= 1'b0;
			kind_q    <= KIND_ECHO;
			char_q    <= CH_NUL;
			rdy_out_q <= 1'b0;
			last_q    <= 1'b0;
		end else if (load) begin
			m_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						unique case (cmd.op)
							OP_PRINT: begin
								if (pos_ok) begin
									pos_q     <= pos_q + 1'b1;
									m_valid_q <= 1'b1;
									kind_q    <= KIND_ECHO;
									char_q    <= cmd.ch;
									rdy_out_q <= ready_q;
									last_q    <= 1'b1;
								end
							end
							OP_BKSP: begin
								if (pos_q != '0) begin
									pos_q     <= pos_q - 1'b1;
									m_valid_q <= 1'b1;
									kind_q    <= KIND_ECHO;
									char_q    <= CH_BS;
									rdy_out_q <= ready_q;
									last_q    <= 1'b0;
									state_q   <= ST_BS_SPACE;
								end
							end
							OP_ENTER: begin
								pos_q     <= '0;
								ready_q   <= 1'b1;
								m_valid_q <= 1'b1;
								kind_q    <= KIND_ECHO;
								char_q    <= CH_NL;
								rdy_out_q <= 1'b1;
								last_q    <= 1'b1;
							end
							OP_READ: begin
								if (!ready_q) begin
									m_valid_q <= 1'b1;
									kind_q    <= KIND_NOLINE;
									char_q    <= CH_NUL;
									rdy_out_q <= 1'b0;
									last_q    <= 1'b1;
								end else begin
									idx_q   <= '0;
									bound_q <= bound_d;
									state_q <= ST_STREAM;
								end
							end
						endcase
					end
				end
				ST_BS_SPACE: begin
					m_valid_q <= 1'b1;
					kind_q    <= KIND_ECHO;
					char_q    <= CH_SP;
					rdy_out_q <= ready_q;
					last_q    <= 1'b0;
					state_q   <= ST_BS_LAST;
				end
				ST_BS_LAST: begin
					m_valid_q <= 1'b1;
					kind_q    <= KIND_ECHO;
					char_q    <= CH_BS;
					rdy_out_q <= ready_q;
					last_q    <= 1'b1;
					state_q   <= ST_IDLE;
				end
				ST_STREAM: begin
					m_valid_q <= 1'b1;
					kind_q    <= KIND_LINE;
					rdy_out_q <= 1'b0;
					if (term) begin
						char_q  <= CH_NUL;
						last_q  <= 1'b1;
						ready_q <= 1'b0;
						state_q <= ST_IDLE;
					end else begin
						char_q <= rdata;
						last_q <= 1'b0;
						idx_q  <= idx_q + 1'b1;
					end
				end
			endcase
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {7'd0, rdy_out_q, char_q};
	assign m_axis_tuser  = kind_q;
	assign m_axis_tlast  = last_q;

endmodule

`default_nettype wire

>>> rtl/scancode_line_editor.sv
// Top level of the scancode line editor: front end, command queue and line engine.
// Depends on sle_pkg, sle_front, sle_queue and sle_back.
//
// Set-1 scancodes and read requests arrive as input beats; the front end maps
// each code to a character in the same cycle and places a command in a
// two-entry queue, so input is taken while the output side is stalled until
// the queue is full. Break codes and keys without a character are absorbed
// there and give no beat. The line engine runs one command at a time: a
// printable key or enter gives one echo beat, an ignored command none,
// backspace three output beats, a read that finds no line one beat. A read of
// a finished line first fetches the first character from the line store, then
// gives one beat per character and a final zero beat; the single read port of
// the line store sets this pace. Output stalls hold the engine beat by beat.
`default_nettype none

module scancode_line_editor import sle_pkg::*; #(
	parameter int unsigned LINE_CAPACITY = LINE_CAPACITY_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,  // [7:0] scancode, [14:8] read_limit
	input  wire logic [0:0]  s_axis_tuser,  // [0] req_type
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [15:0]      m_axis_tdata,  // [7:0] out_char, [8] line_ready
	output logic [1:0]       m_axis_tuser,  // [1:0] out_kind
	output logic             m_axis_tlast   // last
);

	logic fq_valid;
	logic fq_ready;
	cmd_t fq_cmd;
	logic qb_valid;
	logic qb_pop;
	cmd_t qb_cmd;

	sle_front u_front (
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.cmd_valid    (fq_valid),
		.cmd_ready    (fq_ready),
		.cmd          (fq_cmd)
	);

	sle_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (fq_valid),
		.in_ready (fq_ready),
		.in_cmd   (fq_cmd),
		.out_valid(qb_valid),
		.out_pop  (qb_pop),
		.out_cmd  (qb_cmd)
	);

	sle_back #(
		.LINE_CAPACITY(LINE_CAPACITY)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (qb_valid),
		.cmd_pop      (qb_pop),
		.cmd          (qb_cmd),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

endmodule

`default_nettype wire
